// ----- rtl/sfvd_pkg.sv -----
// sfvd_pkg: shared types and constants for the sync frame value deframer
// no dependencies; imported by every rtl module of the block
package sfvd_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hA5;
    localparam logic [7:0] SYNC_SECOND = 8'h5A;
    localparam logic [7:0] TYPE_VALUES = 8'h12;
    localparam logic [7:0] TYPE_SHORT  = 8'h16;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 3;
    localparam int unsigned MAG_W   = 19;
    localparam int unsigned RAW_W   = 15;

    localparam logic [INDEX_W-1:0] LAST_INDEX = 3'd5;

    typedef enum logic [2:0] {
        PH_HUNT     = 3'd0,
        PH_SYNC2    = 3'd1,
        PH_TYPE     = 3'd2,
        PH_SKIP_VAL = 3'd3,
        PH_HIGH     = 3'd4,
        PH_LOW      = 3'd5,
        PH_SKIP_SHT = 3'd6
    } phase_t;

    typedef struct packed {
        logic [INDEX_W-1:0] value_index;
        logic               negative;
        logic [MAG_W-1:0]   magnitude;
        logic               frame_end;
    } result_t;

endpackage

// ----- rtl/sfvd_decode.sv -----
// sfvd_decode: frame phase tracking and value assembly, one byte per cycle while fire is high
// depends on sfvd_pkg
module sfvd_decode
    import sfvd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [BYTE_W-1:0] byte_in,
    output logic              res_valid,
    output result_t           res
);

    phase_t               phase_reg, phase_next;
    logic [BYTE_W-1:0]    high_reg, high_next;
    logic [INDEX_W-1:0]   count_reg, count_next;
    logic [RAW_W-1:0]     raw_mag;
    logic [MAG_W-1:0]     scaled_mag;
    logic                 last;

    assign raw_mag    = {high_reg[BYTE_W-2:0], byte_in};
    // times ten as 8x + 2x
    assign scaled_mag = {1'b0, raw_mag, 3'b000} + {3'b000, raw_mag, 1'b0};
    assign last       = (count_reg >= LAST_INDEX);

    always_comb
    begin
        phase_next = phase_reg;
        high_next  = high_reg;
        count_next = count_reg;
        res_valid  = 1'b0;
        res.value_index = count_reg;
        res.negative    = high_reg[BYTE_W-1] & ~last;
        res.magnitude   = last ? scaled_mag : {{(MAG_W-RAW_W){1'b0}}, raw_mag};
        res.frame_end   = last;
        if (fire)
        begin
            case (phase_reg)
                PH_HUNT:
                    phase_next = (byte_in == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                PH_SYNC2:
                    phase_next = (byte_in == SYNC_SECOND) ? PH_TYPE : PH_HUNT;
                PH_TYPE:
                begin
                    if (byte_in == TYPE_VALUES)
                        phase_next = PH_SKIP_VAL;
                    else if (byte_in == TYPE_SHORT)
                        phase_next = PH_SKIP_SHT;
                    else
                        phase_next = PH_HUNT;
                end
                PH_SKIP_VAL:
                begin
                    count_next = '0;
                    phase_next = PH_HIGH;
                end
                PH_HIGH:
                begin
                    high_next  = byte_in;
                    phase_next = PH_LOW;
                end
                PH_LOW:
                begin
                    res_valid = 1'b1;
                    if (last)
                    begin
                        count_next = '0;
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        phase_next = PH_HIGH;
                    end
                end
                PH_SKIP_SHT:
                    phase_next = PH_HUNT;
                default:
                    phase_next = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            high_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            high_reg  <= high_next;
            count_reg <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LAST_INDEX)
        else $error("value count beyond last index");

    a_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.frame_end) |=> (phase_reg == PH_HUNT && count_reg == '0))
        else $error("frame end did not return to hunting");

    a_skip_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == PH_SKIP_VAL) |=> (phase_reg == PH_HIGH && count_reg == '0))
        else $error("value frame did not start at index zero");

endmodule

// ----- rtl/sfvd_out.sv -----
// sfvd_out: result register feeding the output channel
// depends on sfvd_pkg
module sfvd_out
    import sfvd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    stall,
    output logic    valid,
    output result_t res_out
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign valid_next = load | (valid_reg & stall);
    assign valid      = valid_reg;
    assign res_out    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !(valid_reg && stall))
        else $error("result overwritten while stalled");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not presented");

    a_plain_mag: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !res_reg.frame_end) |-> (res_reg.magnitude < 19'd32768))
        else $error("unscaled magnitude out of range");

endmodule

// ----- rtl/sync_frame_value_deframer.sv -----
// sync_frame_value_deframer: a byte transaction passes through the input register,
// then the result register, to result valid; throughput one byte per cycle unless
// out_stall holds a full result register, a result on every low byte of a value;
// the decode stage advances on a held byte if the result register is empty or drained
// reset (rst_n low, asynchronous) empties both registers and restarts sync hunting
// depends on sfvd_pkg, sfvd_decode, sfvd_out
module sync_frame_value_deframer
    import sfvd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] value_index,
    output logic               negative,
    output logic [MAG_W-1:0]   magnitude,
    output logic               frame_end
);

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              advance;
    logic              res_valid;
    result_t           res;
    result_t           res_out;

    assign advance       = in_valid_reg & (~out_valid | ~out_stall);
    assign in_stall      = in_valid_reg & ~advance;
    assign in_valid_next = in_valid | (in_valid_reg & ~advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // take a new byte whenever the held one leaves or the register is empty
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            byte_reg <= rx_byte;
    end

    sfvd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .byte_in   (byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    sfvd_out u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (res_valid),
        .res     (res),
        .stall   (out_stall),
        .valid   (out_valid),
        .res_out (res_out)
    );

    assign value_index = res_out.value_index;
    assign negative    = res_out.negative;
    assign magnitude   = res_out.magnitude;
    assign frame_end   = res_out.frame_end;

endmodule
